### rtl/sidenv_pkg.sv
`timescale 1ns / 1ps
package sidenv_pkg;

	localparam int DEF_VOICES = 3;
	localparam int DEF_RATE_LIMIT = 32768;
	localparam int CNT_W = 15;
	localparam int LVL_W = 8;
	localparam int PRE_W = 5;

	typedef enum logic [1:0] {
		PH_ATTACK  = 2'd0,
		PH_DECAY   = 2'd1,
		PH_SUSTAIN = 2'd2,
		PH_RELEASE = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		ACT_TICK = 2'd0,
		ACT_CTRL = 2'd1,
		ACT_AD   = 2'd2,
		ACT_SR   = 2'd3
	} action_t;

	typedef struct packed {
		logic [CNT_W-1:0] rate_cnt;
		logic [LVL_W-1:0] level;
		logic [PRE_W-1:0] prescale;
		phase_t           phase;
		logic             locked;
		logic             gate;
		logic [7:0]       ad;
		logic [7:0]       sr;
	} voice_state_t;

	localparam voice_state_t STATE_RESET = '{
		rate_cnt: '0,
		level:    '0,
		prescale: '0,
		phase:    PH_RELEASE,
		locked:   1'b1,
		gate:     1'b0,
		ad:       '0,
		sr:       '0
	};

	function automatic logic [15:0] period_of(input logic [3:0] nib);
		logic [15:0] p;
		case (nib)
			4'd0:    p = 16'd8;
			4'd1:    p = 16'd31;
			4'd2:    p = 16'd62;
			4'd3:    p = 16'd93;
			4'd4:    p = 16'd146;
			4'd5:    p = 16'd215;
			4'd6:    p = 16'd262;
			4'd7:    p = 16'd308;
			4'd8:    p = 16'd384;
			4'd9:    p = 16'd922;
			4'd10:   p = 16'd1920;
			4'd11:   p = 16'd3072;
			4'd12:   p = 16'd3840;
			4'd13:   p = 16'd11518;
			4'd14:   p = 16'd19196;
			4'd15:   p = 16'd30713;
			default: p = 16'd8;
		endcase
		return p;
	endfunction

	function automatic logic [PRE_W-1:0] prescale_of(input logic [LVL_W-1:0] lvl);
		logic [PRE_W-1:0] n;
		if (lvl > 8'd93)
			n = 5'd1;
		else if (lvl > 8'd54)
			n = 5'd2;
		else if (lvl > 8'd26)
			n = 5'd4;
		else if (lvl > 8'd14)
			n = 5'd8;
		else if (lvl > 8'd6)
			n = 5'd16;
		else if (lvl > 8'd0)
			n = 5'd30;
		else
			n = 5'd1;
		return n;
	endfunction

endpackage

### rtl/sid_adsr_envelope_generator.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake          Contents
// s_*       in   s_tvalid/s_tready  tick or byte write for one voice
// m_*       out  m_tvalid/m_tready  voice level and phase after the item
//
// An input item passes through the read and update stage, then the output register, to the result.
// One item per cycle unless output stalls; per-voice state RAM: one read, one write port.
// Back-to-back items to the same voice take the last written state from a bypass register.
// arst_n marks all voices unwritten; an unwritten voice reads as its reset state.
// A stalled output holds the update stage, which then drops s_tready.
module sid_adsr_envelope_generator
	import sidenv_pkg::*;
#(
	parameter int VOICES = DEF_VOICES,
	parameter int RATE_COUNTER_LIMIT = DEF_RATE_LIMIT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [1:0] voice, [9:2] value, [15:10] zero
	input  logic [1:0]  s_tuser,  // [1:0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // [7:0] level, [9:8] phase, [15:10] zero
);

	localparam int VAW = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int SW = $bits(voice_state_t);

	logic             accept;
	logic             s1_go;
	logic             valid_s1;
	action_t          action_s1;
	logic [1:0]       voice_s1;
	logic [7:0]       value_s1;
	logic             inrange_s1;
	logic [VAW-1:0]   addr_s1;
	logic [SW-1:0]    ram_rdata;
	voice_state_t     cur;
	voice_state_t     nxt;
	logic             wr_en;
	logic             wr_valid_q;
	logic [VAW-1:0]   wr_addr_q;
	voice_state_t     wr_data_q;
	logic [VOICES-1:0] written_q;
	logic             m_tvalid_q;
	logic [9:0]       m_data_q;

	assign accept = s_tvalid && s_tready;
	assign s1_go = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= action_t'(s_tuser);
			voice_s1 <= s_tdata[1:0];
			value_s1 <= s_tdata[9:2];
		end
	end

	assign inrange_s1 = (32'(voice_s1) < VOICES);
	assign addr_s1 = VAW'(voice_s1);

	sidenv_ram #(
		.WIDTH(SW),
		.DEPTH(VOICES)
	) u_state_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(addr_s1),
		.wdata(nxt),
		.re   (accept),
		.raddr(VAW'(s_tdata[1:0])),
		.rdata(ram_rdata)
	);

	always_comb begin
		if (wr_valid_q && wr_addr_q == addr_s1)
			cur = wr_data_q;
		else if (inrange_s1 && written_q[addr_s1])
			cur = voice_state_t'(ram_rdata);
		else
			cur = STATE_RESET;
	end

	sidenv_update #(
		.RATE_COUNTER_LIMIT(RATE_COUNTER_LIMIT)
	) u_update (
		.action(action_s1),
		.value (value_s1),
		.cur   (cur),
		.nxt   (nxt)
	);

	assign wr_en = s1_go && inrange_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_valid_q <= 1'b0;
			written_q <= '0;
		end else if (wr_en) begin
			wr_valid_q <= 1'b1;
			written_q[addr_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			wr_addr_q <= addr_s1;
			wr_data_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s1_go) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			if (inrange_s1)
				m_data_q <= {nxt.phase, nxt.level};
			else
				m_data_q <= {PH_RELEASE, 8'd0};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {6'd0, m_data_q};

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && m_tvalid_q && !m_tready) |-> !s_tready)
		else $error("input taken while update stage is stalled");

	a_out_range_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && !inrange_s1) |=> (m_tdata[9:8] == PH_RELEASE && m_tdata[7:0] == 8'd0))
		else $error("unknown voice gave a nonzero result");

	a_attack_no_fall: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && action_s1 == ACT_TICK && cur.phase == PH_ATTACK) |-> (nxt.level >= cur.level))
		else $error("level fell during attack");

	a_zero_locks: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && action_s1 == ACT_TICK && nxt.level == 8'd0 && cur.level != 8'd0)
			|=> (wr_data_q.locked && wr_data_q.level == 8'd0))
		else $error("level reached zero without locking");

endmodule

### rtl/sidenv_ram.sv
`timescale 1ns / 1ps
module sidenv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/sidenv_update.sv
`timescale 1ns / 1ps
module sidenv_update
	import sidenv_pkg::*;
#(
	parameter int RATE_COUNTER_LIMIT = DEF_RATE_LIMIT
) (
	input  action_t      action,
	input  logic [7:0]   value,
	input  voice_state_t cur,
	output voice_state_t nxt
);

	localparam logic [15:0] CNT_LIMIT = 16'(RATE_COUNTER_LIMIT);

	logic [15:0]      cnt_inc;
	logic [CNT_W-1:0] cnt_tick;
	logic [LVL_W-1:0] sus;
	logic [LVL_W-1:0] lvl_up;
	logic [3:0]       nib;
	logic             per_hit;
	logic [PRE_W-1:0] pre_inc;
	logic             pre_hit;

	always_comb begin
		cnt_inc = {1'b0, cur.rate_cnt} + 16'd1;
		cnt_tick = (cnt_inc >= CNT_LIMIT) ? '0 : cnt_inc[CNT_W-1:0];
		sus = {cur.sr[7:4], cur.sr[7:4]};
		lvl_up = (cur.level == 8'hff) ? 8'hff : cur.level + 8'd1;
		case (cur.phase)
			PH_ATTACK: nib = cur.ad[7:4];
			PH_DECAY:  nib = cur.ad[3:0];
			default:   nib = cur.sr[3:0];
		endcase
		per_hit = ({1'b0, cnt_tick} == period_of(nib));
		pre_inc = cur.prescale + 5'd1;
		pre_hit = (pre_inc >= prescale_of(cur.level));

		nxt = cur;
		case (action)
			ACT_TICK: begin
				nxt.rate_cnt = cnt_tick;
				case (cur.phase)
					PH_ATTACK: begin
						if (per_hit) begin
							nxt.rate_cnt = '0;
							if (!cur.locked) begin
								nxt.level = lvl_up;
								nxt.prescale = '0;
								if (lvl_up == 8'hff)
									nxt.phase = PH_DECAY;
							end
						end
					end
					PH_DECAY: begin
						if (per_hit) begin
							nxt.rate_cnt = '0;
							nxt.prescale = pre_hit ? '0 : pre_inc;
							if (pre_hit && !cur.locked) begin
								if (cur.level != sus)
									nxt.level = cur.level - 8'd1;
								else
									nxt.phase = PH_SUSTAIN;
							end
						end
					end
					PH_SUSTAIN: begin
						if (cur.level != sus)
							nxt.phase = PH_DECAY;
					end
					default: begin
						if (per_hit) begin
							nxt.rate_cnt = '0;
							nxt.prescale = pre_hit ? '0 : pre_inc;
							if (pre_hit && !cur.locked)
								nxt.level = cur.level - 8'd1;
						end
					end
				endcase
				if (nxt.level == '0 && cur.level != '0)
					nxt.locked = 1'b1;
			end
			ACT_CTRL: begin
				if (!cur.gate && value[0]) begin
					nxt.phase = PH_ATTACK;
					nxt.locked = 1'b0;
				end else if (cur.gate && !value[0]) begin
					nxt.phase = PH_RELEASE;
				end
				nxt.gate = value[0];
			end
			ACT_AD:  nxt.ad = value;
			default: nxt.sr = value;
		endcase
	end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import sidenv_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int LONG_HOLD = 80;
	localparam int TAIL_CYCLES = 10;
	localparam int RANDOM_ITEMS = 700;

	typedef struct packed {
		logic [LVL_W-1:0] level;
		phase_t           phase;
	} env_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;

	env_result_t expected_q[$];
	int errors = 0;
	int rx_hold = 0;
	int items_sent = 0;
	bit no_gaps = 1'b0;

	int unsigned      rate_cnt [DEF_VOICES];
	int unsigned      exp_cnt  [DEF_VOICES];
	logic [LVL_W-1:0] env_lvl  [DEF_VOICES];
	phase_t           env_ph   [DEF_VOICES];
	bit               locked   [DEF_VOICES];
	bit               gate     [DEF_VOICES];
	logic [7:0]       ad_byte  [DEF_VOICES];
	logic [7:0]       sr_byte  [DEF_VOICES];

	sid_adsr_envelope_generator i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void clear_voices();
		for (int v = 0; v < DEF_VOICES; v++) begin
			rate_cnt[v] = 0;
			exp_cnt[v] = 0;
			env_lvl[v] = '0;
			env_ph[v] = PH_RELEASE;
			locked[v] = 1'b1;
			gate[v] = 1'b0;
			ad_byte[v] = '0;
			sr_byte[v] = '0;
		end
	endfunction

	function automatic int unsigned rate_period(input logic [3:0] nib);
		longint unsigned ms;
		case (nib)
			4'd0: ms = 2;
			4'd1: ms = 8;
			4'd2: ms = 16;
			4'd3: ms = 24;
			4'd4: ms = 38;
			4'd5: ms = 56;
			4'd6: ms = 68;
			4'd7: ms = 80;
			4'd8: ms = 100;
			4'd9: ms = 240;
			4'd10: ms = 500;
			4'd11: ms = 800;
			4'd12: ms = 1000;
			4'd13: ms = 3000;
			4'd14: ms = 5000;
			default: ms = 8000;
		endcase
		return int'(ms * 982800 / 256000) + 1;
	endfunction

	function automatic int unsigned exp_divisor(input logic [LVL_W-1:0] l);
		if (l > 93)
			return 1;
		if (l > 54)
			return 2;
		if (l > 26)
			return 4;
		if (l > 14)
			return 8;
		if (l > 6)
			return 16;
		if (l > 0)
			return 30;
		return 1;
	endfunction

	function automatic bit period_reached(input int v, input int unsigned period);
		if (rate_cnt[v] == period) begin
			rate_cnt[v] = 0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic bit exp_step_due(input int v);
		exp_cnt[v] = (exp_cnt[v] + 1) & 32'h1f;
		if (exp_cnt[v] >= exp_divisor(env_lvl[v])) begin
			exp_cnt[v] = 0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void clock_envelope(input int v);
		logic [LVL_W-1:0] prev;
		logic [LVL_W-1:0] sus;
		prev = env_lvl[v];
		sus = {sr_byte[v][7:4], sr_byte[v][7:4]};
		rate_cnt[v] = (rate_cnt[v] + 1) & 32'hffff;
		if (rate_cnt[v] >= DEF_RATE_LIMIT)
			rate_cnt[v] = 0;
		rate_cnt[v] = rate_cnt[v] & 32'h7fff;
		case (env_ph[v])
			PH_ATTACK: begin
				if (period_reached(v, rate_period(ad_byte[v][7:4])) && !locked[v]) begin
					if (env_lvl[v] != 8'hff)
						env_lvl[v] = env_lvl[v] + 8'd1;
					exp_cnt[v] = 0;
					if (env_lvl[v] == 8'hff)
						env_ph[v] = PH_DECAY;
				end
			end
			PH_DECAY: begin
				if (period_reached(v, rate_period(ad_byte[v][3:0]))) begin
					if (exp_step_due(v) && !locked[v]) begin
						if (env_lvl[v] != sus)
							env_lvl[v] = env_lvl[v] - 8'd1;
						else
							env_ph[v] = PH_SUSTAIN;
					end
				end
			end
			PH_SUSTAIN: begin
				if (env_lvl[v] != sus)
					env_ph[v] = PH_DECAY;
			end
			default: begin
				if (period_reached(v, rate_period(sr_byte[v][3:0]))) begin
					if (exp_step_due(v) && !locked[v])
						env_lvl[v] = env_lvl[v] - 8'd1;
				end
			end
		endcase
		if (env_lvl[v] == 0 && prev > 0)
			locked[v] = 1'b1;
	endfunction

	function automatic env_result_t predict_envelope(input action_t act, input logic [1:0] voice,
			input logic [7:0] val);
		env_result_t r;
		int v;
		v = voice;
		if (v >= DEF_VOICES) begin
			r.level = '0;
			r.phase = PH_RELEASE;
			return r;
		end
		case (act)
			ACT_TICK: clock_envelope(v);
			ACT_CTRL: begin
				if (!gate[v] && val[0]) begin
					env_ph[v] = PH_ATTACK;
					locked[v] = 1'b0;
				end else if (gate[v] && !val[0]) begin
					env_ph[v] = PH_RELEASE;
				end
				gate[v] = val[0];
			end
			ACT_AD: ad_byte[v] = val;
			default: sr_byte[v] = val;
		endcase
		r.level = env_lvl[v];
		r.phase = env_ph[v];
		return r;
	endfunction

	task automatic send_item(input action_t act, input logic [1:0] voice, input logic [7:0] val);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {6'd0, val, voice};
		do
			@(posedge clk);
		while (!s_tready);
		expected_q.push_back(predict_envelope(act, voice, val));
		items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [3:0] fast_rate();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			return 4'd0;
		if (pick < 8)
			return 4'd1;
		return 4'($urandom_range(0, 15));
	endfunction

	task automatic test_directed();
		send_item(ACT_TICK, 2'd0, 8'h00);
		send_item(ACT_TICK, 2'd3, 8'hff);
		send_item(ACT_CTRL, 2'd3, 8'hff);
		send_item(ACT_AD, 2'd3, 8'hff);
		send_item(ACT_SR, 2'd3, 8'h00);
		send_item(ACT_AD, 2'd0, 8'h00);
		send_item(ACT_SR, 2'd0, 8'hf0);
		send_item(ACT_CTRL, 2'd0, 8'hff);
		send_item(ACT_CTRL, 2'd0, 8'h01);
		repeat (9) send_item(ACT_TICK, 2'd0, 8'h55);
		send_item(ACT_CTRL, 2'd0, 8'hfe);
		send_item(ACT_AD, 2'd1, 8'hff);
		send_item(ACT_SR, 2'd1, 8'h0f);
		send_item(ACT_CTRL, 2'd1, 8'h00);
		send_item(ACT_TICK, 2'd2, 8'haa);
	endtask

	task automatic test_backpressure();
		no_gaps = 1'b1;
		rx_hold = LONG_HOLD;
		repeat (40) send_item(ACT_TICK, 2'($urandom_range(0, DEF_VOICES - 1)), 8'($urandom));
		no_gaps = 1'b0;
	endtask

	task automatic test_drain_pause();
		wait_drained();
		repeat (6) send_item(action_t'($urandom_range(0, 3)), 2'($urandom), 8'($urandom));
	endtask

	task automatic run_envelope();
		int v;
		int n;
		int steps;
		v = $urandom_range(0, DEF_VOICES - 1);
		no_gaps = ($urandom_range(0, 4) == 0);
		send_item(ACT_AD, 2'(v), {fast_rate(), fast_rate()});
		send_item(ACT_SR, 2'(v), {4'($urandom_range(0, 15)), fast_rate()});
		steps = $urandom_range(1, 4);
		repeat (steps) begin
			send_item(ACT_CTRL, 2'(v), 8'($urandom));
			n = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
			repeat (n) send_item(ACT_TICK, 2'(v), 8'($urandom));
			if ($urandom_range(0, 3) == 0)
				send_item(ACT_SR, 2'(v), {4'($urandom_range(0, 15)), fast_rate()});
		end
		no_gaps = 1'b0;
	endtask

	task automatic test_random();
		int start;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			if ($urandom_range(0, 6) == 0)
				repeat ($urandom_range(1, 8))
					send_item(action_t'($urandom_range(0, 3)), 2'($urandom), 8'($urandom));
			else
				run_envelope();
		end
	endtask

	initial begin : result_sink
		int stall;
		env_result_t want;
		env_result_t got;
		m_tready = 1'b0;
		stall = 0;
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				rx_hold--;
				m_tready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				stall = no_gaps ? 0 : $urandom_range(0, 11);
				got.level = m_tdata[7:0];
				got.phase = phase_t'(m_tdata[9:8]);
				if (expected_q.size() == 0) begin
					$error("unexpected result: level %0d phase %0d", got.level, got.phase);
					errors++;
				end else begin
					want = expected_q.pop_front();
					if (got.level !== want.level) begin
						$error("level: expected %0d, actual %0d", want.level, got.level);
						errors++;
					end
					if (got.phase !== want.phase) begin
						$error("phase: expected %0d, actual %0d", want.phase, m_tdata[9:8]);
						errors++;
					end
				end
			end
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle = 0;
			else
				idle++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = ACT_TICK;
		clear_voices();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_backpressure();
		test_drain_pause();
		test_random();
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_q.size() != 0) begin
			$error("%0d results never arrived", expected_q.size());
			errors++;
		end
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
